/* rtl/jsu_pkg.sv */
package jsu_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_BODY   = 3'd1,
      MODE_ESC    = 3'd2,
      MODE_HEX    = 3'd3,
      MODE_HEXBAD = 3'd4,
      MODE_LOOK   = 3'd5
   } mode_type;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   localparam logic [2:0] ERR_UNTERM_STR = 3'd0;
   localparam logic [2:0] ERR_UNTERM_ESC = 3'd1;
   localparam logic [2:0] ERR_TRUNC_U    = 3'd2;
   localparam logic [2:0] ERR_BAD_HEX    = 3'd3;
   localparam logic [2:0] ERR_BAD_ESC    = 3'd4;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U = 8'h75;

   localparam logic [15:0] HIGH_MIN = 16'hD800;
   localparam logic [15:0] HIGH_MAX = 16'hDBFF;
   localparam logic [15:0] LOW_MIN  = 16'hDC00;
   localparam logic [15:0] LOW_MAX  = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE = 21'h10000;

   // Depth of the lookahead store: five buffered bytes plus the failing one
   localparam int LookDepth = 6;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [2:0] error_code;
   } result_type;

   typedef struct packed {
      logic       load;
      logic       proc;
      logic       emit;
      logic       flush;
      logic [1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic       q_empty;
      logic       end_pend;
      logic       produce;
      logic       emit_go;
      logic       hold_valid;
      logic       out_free;
      logic [2:0] utf8_len;
   } status_type;

   // {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b inside {[8'h30:8'h39]}) r = {1'b1, 4'(b - 8'h30)};
      else if (b inside {[8'h61:8'h66]}) r = {1'b1, 4'(b - 8'h57)};
      else if (b inside {[8'h41:8'h46]}) r = {1'b1, 4'(b - 8'h37)};
      return r;
   endfunction

   // {valid, decoded byte} for the single-character escapes
   function automatic logic [8:0] esc_map(input logic [7:0] b);
      logic [8:0] r;
      case (b)
         8'h22:   r = {1'b1, 8'h22};
         8'h5C:   r = {1'b1, 8'h5C};
         8'h2F:   r = {1'b1, 8'h2F};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0C};
         8'h6E:   r = {1'b1, 8'h0A};
         8'h72:   r = {1'b1, 8'h0D};
         8'h74:   r = {1'b1, 8'h09};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] utf8_len(input logic [20:0] cp);
      logic [2:0] n;
      if (cp < 21'h80) n = 3'd1;
      else if (cp < 21'h800) n = 3'd2;
      else if (cp < 21'h10000) n = 3'd3;
      else n = 3'd4;
      return n;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] k);
      logic [2:0] n;
      logic [7:0] r;
      n = utf8_len(cp);
      r = 8'h80 | {2'b00, cp[5:0]};
      case (n)
         3'd1: r = cp[7:0];
         3'd2: if (k == 2'd0) r = 8'hC0 | {3'b000, cp[10:6]};
         3'd3: begin
            if (k == 2'd0) r = 8'hE0 | {4'b0000, cp[15:12]};
            else if (k == 2'd1) r = 8'h80 | {2'b00, cp[11:6]};
         end
         default: begin
            if (k == 2'd0) r = 8'hF0 | {5'b00000, cp[20:18]};
            else if (k == 2'd1) r = 8'h80 | {2'b00, cp[17:12]};
            else if (k == 2'd2) r = 8'h80 | {2'b00, cp[11:6]};
         end
      endcase
      return r;
   endfunction

endpackage

/* rtl/jsu_ctrl.sv */
module jsu_ctrl
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_ACCEPT,
      ST_PROC,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic       blocked;

   // a new result needs the held one moved to the output register
   assign blocked = status.hold_valid && !status.out_free;
   assign req_tready = (state_ff == ST_ACCEPT);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cmd = '0;
      cmd.idx = idx_ff;
      case (state_ff)
         ST_ACCEPT: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PROC;
            end
         end
         ST_PROC: begin
            if (status.q_empty && !status.end_pend) begin
               state_in = ST_FLUSH;
            end else if (!(status.produce && blocked)) begin
               cmd.proc = 1'b1;
               if (status.emit_go) begin
                  state_in = ST_EMIT;
                  idx_in = 2'd0;
               end
            end
         end
         ST_EMIT: begin
            if (!blocked) begin
               cmd.emit = 1'b1;
               if ({1'b0, idx_ff} == status.utf8_len - 3'd1) state_in = ST_PROC;
               else idx_in = idx_ff + 2'd1;
            end
         end
         ST_FLUSH: begin
            if (!status.hold_valid) begin
               state_in = ST_ACCEPT;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in = ST_ACCEPT;
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
         idx_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end

endmodule

/* rtl/jsu_datapath.sv */
module jsu_datapath
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_tdata,
   input  logic [0:0]  req_tuser,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   mode_type   mode_ff, mode_in;
   logic [15:0] hv_ff, hv_in;
   logic [2:0]  hc_ff, hc_in;
   logic [9:0]  ph_ff, ph_in;
   logic [2:0]  lcnt_ff, lcnt_in;
   logic [7:0]  look_ff [LookDepth];
   logic [7:0]  look_wdata;
   logic [2:0]  look_waddr;
   logic        look_we;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        end_pend_ff, end_pend_in;
   logic [2:0]  q_head_ff, q_head_in;
   logic [2:0]  q_len_ff, q_len_in;
   logic        q_buf_ff, q_buf_in;
   logic [20:0] cp_ff, cp_in;
   result_type  hold_ff;
   logic        hold_valid_ff;
   result_type  out_ff;
   logic        out_last_ff;
   logic        out_valid_ff;

   logic        q_empty;
   logic [7:0]  b;
   logic [4:0]  hd;
   logic [8:0]  em;
   logic [15:0] hv_new;
   logic [2:0]  hc_new;
   logic        step_prod;
   result_type  step_res;
   logic        step_emit;
   logic        do_fail;
   logic        fail_cur;
   logic        go_idle;
   logic        push_new;
   result_type  new_res;
   logic        out_free;

   assign q_empty = (q_head_ff == q_len_ff);
   assign b = q_buf_ff ? look_ff[q_head_ff] : in_byte_ff;
   assign hd = hex_digit(b);
   assign em = esc_map(b);
   assign hv_new = {hv_ff[11:0], hd[3:0]};
   assign hc_new = hc_ff + 3'd1;

   // one parse step on the byte at the queue head, or the end of text
   always_comb begin
      mode_in = mode_ff;
      hv_in = hv_ff;
      hc_in = hc_ff;
      ph_in = ph_ff;
      lcnt_in = lcnt_ff;
      end_pend_in = end_pend_ff;
      q_head_in = q_head_ff + 3'd1;
      q_len_in = q_len_ff;
      q_buf_in = q_buf_ff;
      cp_in = cp_ff;
      look_we = 1'b0;
      look_waddr = lcnt_ff;
      look_wdata = b;
      step_prod = 1'b0;
      step_res = '{kind: KIND_BYTE, data_byte: b, error_code: ERR_UNTERM_STR};
      step_emit = 1'b0;
      do_fail = 1'b0;
      fail_cur = 1'b1;
      go_idle = 1'b0;
      if (q_empty) begin
         q_head_in = q_head_ff;
         if (mode_ff == MODE_LOOK) begin
            do_fail = 1'b1;
            fail_cur = 1'b0;
         end else begin
            end_pend_in = 1'b0;
            go_idle = 1'b1;
            step_res.kind = KIND_ERR;
            step_res.data_byte = 8'd0;
            case (mode_ff)
               MODE_BODY: step_prod = 1'b1;
               MODE_ESC: begin
                  step_prod = 1'b1;
                  step_res.error_code = ERR_UNTERM_ESC;
               end
               MODE_HEX, MODE_HEXBAD: begin
                  step_prod = 1'b1;
                  step_res.error_code = ERR_TRUNC_U;
               end
               default: step_prod = 1'b0;
            endcase
         end
      end else begin
         case (mode_ff)
            MODE_BODY: begin
               if (b == CH_QUOTE) begin
                  step_prod = 1'b1;
                  step_res.kind = KIND_DONE;
                  step_res.data_byte = 8'd0;
                  go_idle = 1'b1;
               end else if (b == CH_BSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  step_prod = 1'b1;
               end
            end
            MODE_ESC: begin
               mode_in = MODE_BODY;
               if (em[8]) begin
                  step_prod = 1'b1;
                  step_res.data_byte = em[7:0];
               end else if (b == CH_U) begin
                  mode_in = MODE_HEX;
                  hv_in = 16'd0;
                  hc_in = 3'd0;
               end else begin
                  step_prod = 1'b1;
                  step_res.kind = KIND_ERR;
                  step_res.data_byte = 8'd0;
                  step_res.error_code = ERR_BAD_ESC;
                  go_idle = 1'b1;
               end
            end
            MODE_HEX, MODE_HEXBAD: begin
               hc_in = hc_new;
               if (mode_ff == MODE_HEX && hd[4]) hv_in = hv_new;
               else mode_in = MODE_HEXBAD;
               if (hc_new[2]) begin
                  if (mode_ff == MODE_HEX && hd[4]) begin
                     hv_in = 16'd0;
                     hc_in = 3'd0;
                     if (hv_new inside {[HIGH_MIN:HIGH_MAX]}) begin
                        ph_in = hv_new[9:0];
                        lcnt_in = 3'd0;
                        mode_in = MODE_LOOK;
                     end else begin
                        cp_in = {5'd0, hv_new};
                        step_emit = 1'b1;
                        mode_in = MODE_BODY;
                     end
                  end else begin
                     step_prod = 1'b1;
                     step_res.kind = KIND_ERR;
                     step_res.data_byte = 8'd0;
                     step_res.error_code = ERR_BAD_HEX;
                     go_idle = 1'b1;
                  end
               end
            end
            MODE_LOOK: begin
               if (lcnt_ff == 3'd0) begin
                  do_fail = (b != CH_BSLASH);
               end else if (lcnt_ff == 3'd1) begin
                  do_fail = (b != CH_U);
               end else begin
                  do_fail = !hd[4];
                  hv_in = hv_new;
               end
               if (!do_fail) begin
                  if (lcnt_ff != 3'd5) begin
                     look_we = 1'b1;
                     lcnt_in = lcnt_ff + 3'd1;
                  end else if (hv_new inside {[LOW_MIN:LOW_MAX]}) begin
                     cp_in = SUPP_BASE + 21'({ph_ff, hv_new[9:0]});
                     step_emit = 1'b1;
                     ph_in = 10'd0;
                     lcnt_in = 3'd0;
                     hv_in = 16'd0;
                     mode_in = MODE_BODY;
                  end else begin
                     do_fail = 1'b1;
                  end
               end
            end
            default: begin
               if (b == CH_QUOTE) begin
                  go_idle = 1'b1;
               end
            end
         endcase
      end
      if (go_idle) begin
         mode_in = (mode_ff == MODE_IDLE || mode_ff > MODE_LOOK) && !q_empty
            ? MODE_BODY : MODE_IDLE;
         hv_in = 16'd0;
         hc_in = 3'd0;
         ph_in = 10'd0;
         lcnt_in = 3'd0;
      end
      // lost lookahead: emit the high surrogate, then replay the buffered bytes
      if (do_fail) begin
         cp_in = {5'd0, 6'b110110, ph_ff};
         step_emit = 1'b1;
         look_we = fail_cur;
         q_len_in = lcnt_ff + {2'b00, fail_cur};
         q_head_in = 3'd0;
         q_buf_in = 1'b1;
         ph_in = 10'd0;
         lcnt_in = 3'd0;
         hv_in = 16'd0;
         hc_in = 3'd0;
         mode_in = MODE_BODY;
      end
   end

   assign out_free = !out_valid_ff || rsp_tready;
   assign push_new = (cmd.proc && step_prod) || cmd.emit;

   always_comb begin
      if (cmd.emit) begin
         new_res = '{kind: KIND_BYTE, data_byte: utf8_byte(cp_ff, cmd.idx),
                     error_code: ERR_UNTERM_STR};
      end else begin
         new_res = step_res;
      end
   end

   always_comb begin
      status.q_empty = q_empty;
      status.end_pend = end_pend_ff;
      status.produce = step_prod;
      status.emit_go = step_emit;
      status.hold_valid = hold_valid_ff;
      status.out_free = out_free;
      status.utf8_len = utf8_len(cp_ff);
   end

   assign in_byte_in = req_tdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         hv_ff <= 16'd0;
         hc_ff <= 3'd0;
         ph_ff <= 10'd0;
         lcnt_ff <= 3'd0;
         end_pend_ff <= 1'b0;
         q_head_ff <= 3'd0;
         q_len_ff <= 3'd0;
         q_buf_ff <= 1'b0;
      end else if (cmd.load) begin
         end_pend_ff <= req_tuser[0];
         q_head_ff <= 3'd0;
         q_len_ff <= req_tuser[0] ? 3'd0 : 3'd1;
         q_buf_ff <= 1'b0;
      end else if (cmd.proc) begin
         mode_ff <= mode_in;
         hv_ff <= hv_in;
         hc_ff <= hc_in;
         ph_ff <= ph_in;
         lcnt_ff <= lcnt_in;
         end_pend_ff <= end_pend_in;
         q_head_ff <= q_head_in;
         q_len_ff <= q_len_in;
         q_buf_ff <= q_buf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) in_byte_ff <= in_byte_in;
      if (cmd.proc) begin
         cp_ff <= cp_in;
         if (look_we) look_ff[look_waddr] <= look_wdata;
      end
   end

   // hold stage keeps the newest result until it is known whether it ends the item
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (push_new) begin
            hold_valid_ff <= 1'b1;
            if (hold_valid_ff) out_valid_ff <= 1'b1;
            else if (rsp_tready) out_valid_ff <= 1'b0;
         end else if (cmd.flush && hold_valid_ff) begin
            hold_valid_ff <= 1'b0;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_new) begin
         hold_ff <= new_res;
         if (hold_valid_ff) begin
            out_ff <= hold_ff;
            out_last_ff <= 1'b0;
         end
      end else if (cmd.flush && hold_valid_ff) begin
         out_ff <= hold_ff;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {5'b00000, out_ff.error_code, out_ff.data_byte};
   assign rsp_tuser = out_ff.kind;
   assign rsp_tlast = out_last_ff;

endmodule

/* rtl/json_string_unescape_utf8.sv */
// JSON string unescaper: takes one text byte per item (req_tuser marks end of
// text) and returns the decoded UTF-8 bytes, a string-complete marker or an error,
// with rsp_tlast on the final result of each item. One item at a time: a plain
// byte passes through accept, decode, end-of-item check and hand-off of the held
// result. A \u escape that completes then emits its UTF-8 bytes one by one.
// A high surrogate whose lookahead fails emits its own bytes, then replays each
// buffered byte through the parse sequencer. A stalled result channel holds the
// sequencer until the held result can move on.
module json_string_unescape_utf8
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic [0:0]  req_tuser,   // [0] text_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [10:8] error_code
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   jsu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   jsu_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/jsu_checker.sv */
module jsu_checker
   import jsu_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("stalled rsp item changed");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("bad rsp kind");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_BYTE |-> rsp_tdata[7:0] == 8'd0 && rsp_tlast)
      else $error("marker or error item carries data or is not last");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_ERR |-> rsp_tdata[10:8] == 3'd0)
      else $error("error code set on non-error item");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while the first is in work");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
